@@ src/spo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spo_pkg
// Shared constants and types of the smoothed pulse oscillator.
// ----------------------------------------------------------------------------
package spo_pkg;

   localparam int TABLE_BITS  = 9;
   localparam int FRAC_BITS   = 32;
   localparam int SAMPLE_BITS = 16;

   localparam int PHASE_W = TABLE_BITS + FRAC_BITS;
   localparam int LW_W    = TABLE_BITS + 16;
   localparam int CMP_W   = 34;
   localparam int RND_SH  = 31 - SAMPLE_BITS;
   localparam int DIV_W   = 31;
   localparam int CNT_W   = 5;

   localparam logic [CMP_W-1:0] LW_MAX  = (CMP_W'(1) << LW_W) - CMP_W'(1);
   localparam logic [CMP_W-1:0] TOP_POS = CMP_W'(1) << LW_W;
   localparam logic signed [31:0] PLATEAU   = 32'sd715827883;
   localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
   localparam logic signed [33:0] RND_HALF  = 34'sd1 <<< (RND_SH - 1);
   localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

   localparam logic [31:0] PPH_RESET   = 32'd49864472;
   localparam logic [15:0] FLIM_RESET  = 16'd10000;
   localparam logic [31:0] SPH_RESET   = 32'd109951163;
   localparam logic [15:0] PW_RESET    = 16'd32768;

   localparam logic [1:0] REG_PHASE_PER_HZ = 2'd0;
   localparam logic [1:0] REG_FREQ_LIMIT   = 2'd1;
   localparam logic [1:0] REG_SLEW_PER_HZ  = 2'd2;
   localparam logic [1:0] REG_PULSE_WIDTH  = 2'd3;

   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_SET_PHASE = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_MULS   = 11'b00000000010,
      ST_MULP   = 11'b00000000100,
      ST_EVAL   = 11'b00000001000,
      ST_DIV    = 11'b00000010000,
      ST_SQR    = 11'b00000100000,
      ST_CUBE   = 11'b00001000000,
      ST_THIRD  = 11'b00010000000,
      ST_SMOOTH = 11'b00100000000,
      ST_INTERP = 11'b01000000000,
      ST_FINAL  = 11'b10000000000
   } state_type;

endpackage

@@ src/smoothed_pulse_oscillator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_pulse_oscillator_top
// Band-limited pulse oscillator on a phase accumulator, smoothed ramps.
//
//   channel | ports                                  | direction
//   req     | req_valid/ready, opcode, frequency,    | in
//           | phase_value                            |
//   rsp     | rsp_valid/ready, sample                | out
//   csr     | csr_valid/ready, index, data           | in
//
// When both neighbours lie on a ramp, a sample uses two 31-step restoring
// divisions plus one shared 32x32 multiplier for slew, phase step, square,
// cube, third and interpolation. With one neighbour on a ramp it uses one
// division, with none no division. The block is ready again in the same cycle
// that rsp_valid rises; a phase load leaves it ready.
// Reset is synchronous; only control and CSR registers get documented values.
// A finished sample waits in FINAL while the previous result is unread.
// ----------------------------------------------------------------------------
module smoothed_pulse_oscillator_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_opcode,
   input  logic signed [31:0]                     req_frequency,
   input  logic [31:0]                            req_phase_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [spo_pkg::SAMPLE_BITS-1:0] rsp_sample,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [31:0]                            csr_data
);

   localparam int PW  = spo_pkg::PHASE_W;
   localparam int CW  = spo_pkg::CMP_W;
   localparam int LWW = spo_pkg::LW_W;
   localparam int TB  = spo_pkg::TABLE_BITS;
   localparam int FB  = spo_pkg::FRAC_BITS;
   localparam int SB  = spo_pkg::SAMPLE_BITS;

   spo_pkg::state_type state_ff, state_in;

   logic [31:0] pph_ff, sph_ff;
   logic [15:0] flim_ff, pw_ff;
   logic [PW-1:0] phase_ff, phase_in, inc_ff, inc_in;
   logic [LWW-1:0] lw_ff, lw_in;
   logic pdone_ff, pdone_in;
   logic [31:0] mag_ff, mag_in, s_ff, s_in;
   logic [63:0] prod_ff;
   logic [31:0] opa, opb;
   logic nb_ff, nb_in, ok_ff, ok_in, neg_ff, neg_in;
   logic [32:0] rem_ff, rem_in;
   logic [spo_pkg::DIV_W-1:0] a_ff, a_in;
   logic [spo_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [31:0] f1_ff, f1_in, f2_ff, f2_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0] sample_ff, sample_in;

   logic [31:0] neg_fr, abs_fr, lim;
   logic [TB+31:0] pv_ext;
   logic [CW-1:0] pos_c, s_c, lw_c, sl_c, tn_c, pw_c, w_c;
   logic [32:0] rem_sub;
   logic ge;
   logic [31:0] m_c;
   logic signed [31:0] f_c;
   logic signed [32:0] d_c;
   logic [31:0] ad_c, p_c;
   logic signed [33:0] v_c, sum_c;
   logic [SB-1:0] q_c;
   logic out_free;

   assign req_ready  = (state_ff == spo_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      neg_fr = 32'(-req_frequency);
      abs_fr = req_frequency[31] ? neg_fr : req_frequency;
      lim    = {flim_ff, 16'b0};
      pv_ext = {req_phase_value, TB'(0)};

      s_c   = CW'(s_ff);
      lw_c  = CW'(lw_ff);
      sl_c  = s_c + lw_c;
      pos_c = (CW'(phase_ff[PW-1 -: TB]) + CW'(nb_ff)) << 16;
      pw_c  = CW'(pw_ff) << 9;
      if (pw_c < s_c) begin
         w_c = s_c;
      end else if (s_c <= spo_pkg::TOP_POS && pw_c > spo_pkg::TOP_POS - s_c) begin
         w_c = spo_pkg::TOP_POS - s_c;
      end else begin
         w_c = pw_c;
      end

      rem_sub = rem_ff - {1'b0, s_ff};
      ge      = rem_ff >= {1'b0, s_ff};

      m_c = {1'b0, a_ff} - {1'b0, prod_ff[63:33]};
      f_c = neg_ff ? -$signed(m_c) : $signed(m_c);

      d_c  = {f2_ff[31], f2_ff} - {f1_ff[31], f1_ff};
      ad_c = d_c[32] ? 32'(-d_c) : d_c[31:0];
      p_c  = prod_ff[FB +: 32];
      if (!ok_ff) begin
         v_c = '0;
      end else if (d_c[32]) begin
         v_c = 34'(f1_ff) - $signed({2'b0, p_c});
      end else begin
         v_c = 34'(f1_ff) + $signed({2'b0, p_c});
      end
      sum_c = v_c + spo_pkg::ONE_Q30 + spo_pkg::RND_HALF;
      q_c   = sum_c[spo_pkg::RND_SH +: SB];
      q_c[SB-1] = ~q_c[SB-1];
   end

   always_comb begin
      opa = '0;
      opb = '0;
      case (state_ff)
         spo_pkg::ST_MULS: begin
            opa = mag_ff;
            opb = sph_ff;
         end
         spo_pkg::ST_MULP: begin
            opa = mag_ff;
            opb = pph_ff;
         end
         spo_pkg::ST_SQR: begin
            opa = 32'(a_ff);
            opb = 32'(a_ff);
         end
         spo_pkg::ST_CUBE: begin
            opa = prod_ff[61:30];
            opb = 32'(a_ff);
         end
         spo_pkg::ST_THIRD: begin
            opa = prod_ff[61:30];
            opb = spo_pkg::RECIP3;
         end
         spo_pkg::ST_INTERP, spo_pkg::ST_FINAL: begin
            opa = ad_c;
            opb = 32'(phase_ff[FB-1:0]);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      inc_in       = inc_ff;
      lw_in        = lw_ff;
      pdone_in     = pdone_ff;
      mag_in       = mag_ff;
      s_in         = s_ff;
      nb_in        = nb_ff;
      ok_in        = ok_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      a_in         = a_ff;
      cnt_in       = cnt_ff;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tn_c         = '0;
      case (state_ff)
         spo_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == spo_pkg::OP_SET_PHASE) begin
                  phase_in = pv_ext[(32 - FB) +: PW];
               end else begin
                  mag_in   = (abs_fr > lim) ? lim : abs_fr;
                  nb_in    = 1'b0;
                  ok_in    = 1'b1;
                  state_in = spo_pkg::ST_MULS;
               end
            end
         end
         spo_pkg::ST_MULS: begin
            state_in = spo_pkg::ST_MULP;
         end
         spo_pkg::ST_MULP: begin
            s_in     = prod_ff[63:32];
            state_in = spo_pkg::ST_EVAL;
         end
         spo_pkg::ST_EVAL: begin
            if (!nb_ff) begin
               inc_in = prod_ff[(48 - FB) +: PW];
            end
            state_in = spo_pkg::ST_SMOOTH;
            if (pos_c <= s_c) begin
               if (!nb_ff && pdone_ff) begin
                  lw_in    = (w_c > spo_pkg::LW_MAX) ? spo_pkg::LW_MAX[LWW-1:0] : w_c[LWW-1:0];
                  pdone_in = 1'b0;
               end
               tn_c = (s_c - pos_c) << 1;
               if (s_c >= tn_c) begin
                  rem_in = 33'(s_c - tn_c);
                  neg_in = 1'b0;
               end else begin
                  rem_in = 33'(tn_c - s_c);
                  neg_in = 1'b1;
               end
               if (s_ff == '0) begin
                  ok_in = 1'b0;
               end else begin
                  state_in = spo_pkg::ST_DIV;
               end
            end else if (pos_c < lw_c) begin
               neg_in = 1'b0;
               a_in   = spo_pkg::PLATEAU[spo_pkg::DIV_W-1:0];
            end else if (pos_c <= sl_c) begin
               if (!nb_ff) begin
                  pdone_in = 1'b1;
               end
               tn_c = (sl_c - pos_c) << 1;
               if (s_c >= tn_c) begin
                  rem_in = 33'(s_c - tn_c);
                  neg_in = 1'b1;
               end else begin
                  rem_in = 33'(tn_c - s_c);
                  neg_in = 1'b0;
               end
               if (s_ff == '0) begin
                  ok_in = 1'b0;
               end else begin
                  state_in = spo_pkg::ST_DIV;
               end
            end else begin
               neg_in = 1'b1;
               a_in   = spo_pkg::PLATEAU[spo_pkg::DIV_W-1:0];
            end
            cnt_in = spo_pkg::CNT_W'(spo_pkg::DIV_W - 1);
         end
         spo_pkg::ST_DIV: begin
            rem_in = {ge ? rem_sub[31:0] : rem_ff[31:0], 1'b0};
            a_in   = {a_ff[spo_pkg::DIV_W-2:0], ge};
            cnt_in = cnt_ff - spo_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = spo_pkg::ST_SQR;
            end
         end
         spo_pkg::ST_SQR: begin
            state_in = spo_pkg::ST_CUBE;
         end
         spo_pkg::ST_CUBE: begin
            state_in = spo_pkg::ST_THIRD;
         end
         spo_pkg::ST_THIRD: begin
            state_in = spo_pkg::ST_SMOOTH;
         end
         spo_pkg::ST_SMOOTH: begin
            if (nb_ff) begin
               f2_in    = f_c;
               state_in = spo_pkg::ST_INTERP;
            end else begin
               f1_in    = f_c;
               nb_in    = 1'b1;
               state_in = spo_pkg::ST_EVAL;
            end
         end
         spo_pkg::ST_INTERP: begin
            state_in = spo_pkg::ST_FINAL;
         end
         spo_pkg::ST_FINAL: begin
            if (out_free) begin
               sample_in    = q_c;
               rsp_valid_in = 1'b1;
               phase_in     = phase_ff + inc_ff;
               state_in     = spo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff   <= opa * opb;
      mag_ff    <= mag_in;
      s_ff      <= s_in;
      inc_ff    <= inc_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      a_ff      <= a_in;
      cnt_ff    <= cnt_in;
      f1_ff     <= f1_in;
      f2_ff     <= f2_in;
      sample_ff <= sample_in;
      nb_ff     <= nb_in;
      ok_ff     <= ok_in;
      if (reset) begin
         state_ff     <= spo_pkg::ST_IDLE;
         phase_ff     <= '0;
         lw_ff        <= LWW'({spo_pkg::PW_RESET, 9'b0});
         pdone_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         pph_ff       <= spo_pkg::PPH_RESET;
         flim_ff      <= spo_pkg::FLIM_RESET;
         sph_ff       <= spo_pkg::SPH_RESET;
         pw_ff        <= spo_pkg::PW_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         lw_ff        <= lw_in;
         pdone_ff     <= pdone_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               spo_pkg::REG_PHASE_PER_HZ: pph_ff  <= csr_data;
               spo_pkg::REG_FREQ_LIMIT:   flim_ff <= csr_data[15:0];
               spo_pkg::REG_SLEW_PER_HZ:  sph_ff  <= csr_data;
               spo_pkg::REG_PULSE_WIDTH: begin
                  if (csr_data[15:0] != '0) begin
                     pw_ff <= csr_data[15:0];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == spo_pkg::OP_SAMPLE) |=> !req_ready)
      else $error("sample transfer did not start the sequencer");

   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == spo_pkg::OP_SET_PHASE) |=> req_ready)
      else $error("phase load left the sequencer busy");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == spo_pkg::ST_FINAL))
      else $error("result raised outside the final step");

endmodule
